// ===== design/osrt_pkg.sv =====
// Shared types and codes for the onset-sorted record table.
`default_nettype none

package osrt_pkg;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SORT   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [7:0]          index;
        logic signed [63:0]  onset_in;
        logic [31:0]         payload_in;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic signed [63:0]  onset_out;
        logic [31:0]         payload_out;
        logic [8:0]          entry_count;
    } t_rsp;

endpackage

`default_nettype wire

// ===== design/osrt_if.sv =====
// Request and response stream interfaces of the onset-sorted record table.
`default_nettype none

interface osrt_req_if;
    import osrt_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface osrt_rsp_if;
    import osrt_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/onset_sorted_record_table_core.sv =====
// Record table in arrival order with append, remove, read, stable sort and clear.
// Usage:
//   i_req (sink) takes one request per transfer; o_rsp (source) returns exactly
//   one response per request, with status and the count held afterwards.
//   Records live in one memory with one write port and one registered read
//   port; a small sequencer and one signed key comparator do all the work.
//   Append, clear, unused codes and refused requests go from idle straight to
//   the done state; read takes one registered memory read; remove at index k
//   moves every record above k down one place; sort takes each record i
//   (1..N-1, N = records held) in turn and moves it past the larger records
//   before it. Each moved record is one read and one write through the
//   memory port. One request is in work at a time; i_req.ready is high only
//   while the sequencer is idle.
//   A finished response sits in an output register; the sequencer returns to
//   idle as soon as it has moved its result there, so a stalled receiver holds
//   only the response, and a second result waits until the first transfers.
//   Reset (synchronous, active low) empties the table and drops any response;
//   memory contents are not cleared, entries at or above the count are unused.
`default_nettype none

module onset_sorted_record_table_core #(
    parameter int DEPTH         = 256,
    parameter int KEY_WIDTH     = 64,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    osrt_req_if.sink    i_req,
    osrt_rsp_if.source  o_rsp
);
    import osrt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = KEY_WIDTH + PAYLOAD_WIDTH;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DONE   = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_RM_RD  = 4'd3;
    localparam logic [3:0] S_RM_WR  = 4'd4;
    localparam logic [3:0] S_SO_LD  = 4'd5;
    localparam logic [3:0] S_SO_HLD = 4'd6;
    localparam logic [3:0] S_SO_CMP = 4'd7;
    localparam logic [3:0] S_SO_PLC = 4'd8;

    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_rdata;

    logic [3:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_i, n_i;
    logic [AW-1:0]       r_j, n_j;
    logic [WW-1:0]       r_hold, n_hold;
    logic [STATUS_W-1:0] r_status, n_status;
    logic signed [63:0]  r_onset, n_onset;
    logic [31:0]         r_payload, n_payload;
    t_rsp                r_out;
    logic                r_out_valid;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [WW-1:0] wr_data;
    logic [AW-1:0] rd_addr;

    logic                        req_fire;
    logic                        idx_ok;
    logic [CW-1:0]               next_i;
    logic                        sort_last;
    logic                        load_out;
    logic signed [KEY_WIDTH-1:0] cur_key;
    logic signed [KEY_WIDTH-1:0] hold_key;
    logic                        key_gt;

    assign req_fire  = i_req.valid && i_req.ready;
    assign idx_ok    = 32'(i_req.data.index) < 32'(r_count);
    assign next_i    = r_i + CW'(1);
    assign sort_last = (next_i == r_count);
    assign load_out  = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // The single comparator used by every compare step of the sort.
    assign cur_key  = r_rdata[WW-1:PAYLOAD_WIDTH];
    assign hold_key = r_hold[WW-1:PAYLOAD_WIDTH];
    assign key_gt   = cur_key > hold_key;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_i       = r_i;
        n_j       = r_j;
        n_hold    = r_hold;
        n_status  = r_status;
        n_onset   = r_onset;
        n_payload = r_payload;
        wr_en     = 1'b0;
        wr_addr   = r_j;
        wr_data   = r_hold;
        rd_addr   = r_j - AW'(1);

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_status  = ST_OK;
                    n_onset   = '0;
                    n_payload = '0;
                    n_state   = S_DONE;
                    unique case (i_req.data.action)
                        ACT_APPEND: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_count[AW-1:0];
                                wr_data = {KEY_WIDTH'(i_req.data.onset_in),
                                           PAYLOAD_WIDTH'(i_req.data.payload_in)};
                                n_count = r_count + CW'(1);
                            end
                        end
                        ACT_REMOVE: begin
                            if (!idx_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_i     = CW'(i_req.data.index);
                                n_state = S_RM_RD;
                            end
                        end
                        ACT_READ: begin
                            if (!idx_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                rd_addr = AW'(i_req.data.index);
                                n_state = S_RD;
                            end
                        end
                        ACT_SORT: begin
                            if (r_count > CW'(1)) begin
                                n_i     = CW'(1);
                                n_state = S_SO_LD;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                n_onset   = 64'($signed(r_rdata[WW-1:PAYLOAD_WIDTH]));
                n_payload = 32'(r_rdata[PAYLOAD_WIDTH-1:0]);
                n_state   = S_DONE;
            end
            S_RM_RD: begin
                if (next_i < r_count) begin
                    rd_addr = next_i[AW-1:0];
                    n_state = S_RM_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_RM_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_i[AW-1:0];
                wr_data = r_rdata;
                n_i     = next_i;
                n_state = S_RM_RD;
            end
            S_SO_LD: begin
                rd_addr = r_i[AW-1:0];
                n_j     = r_i[AW-1:0];
                n_state = S_SO_HLD;
            end
            S_SO_HLD: begin
                n_hold  = r_rdata;
                n_state = S_SO_CMP;
            end
            S_SO_CMP: begin
                wr_en = 1'b1;
                if (key_gt) begin
                    // Shift the larger record up and look one place further down.
                    wr_data = r_rdata;
                    n_j     = r_j - AW'(1);
                    rd_addr = r_j - AW'(2);
                    if (r_j == AW'(1)) begin
                        n_state = S_SO_PLC;
                    end
                end else begin
                    n_i     = next_i;
                    n_state = sort_last ? S_DONE : S_SO_LD;
                end
            end
            S_SO_PLC: begin
                wr_en   = 1'b1;
                n_i     = next_i;
                n_state = sort_last ? S_DONE : S_SO_LD;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_hold    <= n_hold;
        r_status  <= n_status;
        r_onset   <= n_onset;
        r_payload <= n_payload;
        if (load_out) begin
            r_out.status      <= r_status;
            r_out.onset_out   <= r_onset;
            r_out.payload_out <= r_payload;
            r_out.entry_count <= 9'(r_count);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("record count exceeds table depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && i_req.data.action == ACT_APPEND && r_count != CW'(DEPTH))
        |=> r_count == $past(r_count) + CW'(1))
        else $error("append did not add one record");

    a_sort_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SO_LD || r_state == S_SO_HLD || r_state == S_SO_CMP ||
         r_state == S_SO_PLC) |=> $stable(r_count))
        else $error("record count changed during sort");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_status == ST_FULL) |-> r_count == CW'(DEPTH))
        else $error("full status reported on a table with room");

    a_sort_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SO_CMP || r_state == S_SO_LD) |-> r_i < r_count)
        else $error("sort position runs past the held records");

endmodule

`default_nettype wire
